// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_PROP(lbl, clk, rst, !(expr), msg)

`endif

// ----- hw/rtl/gtc_pkg.sv -----
`default_nettype none

package gtc_pkg;

   localparam int ROW_INDEX_W = 4;
   localparam int ROW_W = 16;
   localparam int COUNT_W = 5;
   localparam int NODE_W = 4;
   localparam int COLOR_W = 2;

   localparam int DEF_MAX_NODES = 16;
   localparam int DEF_NUM_COLORS = 3;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;
   localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd0;

   typedef struct packed {
      logic load_ready;
      logic start;
      logic step_adv;
      logic step_back;
      logic emit_begin;
      logic found;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic trigger;
      logic fit;
      logic level_zero;
      logic level_full;
      logic out_free;
      logic emit_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gtc_ifs.sv -----
`default_nettype none

interface gtc_req_if;
   logic                               valid;
   logic                               ready;
   logic [gtc_pkg::ROW_INDEX_W-1:0]    row_index;
   logic [gtc_pkg::ROW_W-1:0]          row_bits;
   modport source (output valid, output row_index, output row_bits, input ready);
   modport sink (input valid, input row_index, input row_bits, output ready);
endinterface

interface gtc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [gtc_pkg::NODE_W-1:0]         node;
   logic [gtc_pkg::COLOR_W-1:0]        color;
   logic                               found;
   logic                               last;
   modport source (output valid, output node, output color, output found, output last,
                   input ready);
   modport sink (input valid, input node, input color, input found, input last,
                 output ready);
endinterface

interface gtc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [gtc_pkg::COUNT_W-1:0]        data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/graph_three_coloring_search.sv -----
// graph three-coloring search
// req_port takes one adjacency row per word: row_index names the node and
// row_bits holds its edges, rows sent in order. csr_port writes node_count
// (1..MAX_NODES, 0 acts as 1), by the user only while the block is idle (unenforced).
// The word carrying row node_count-1 starts a depth-first search that gives
// each node the lowest color with no lower-numbered neighbour holding it,
// backtracking when none fits. Rows load at one word per cycle; req_port is
// not ready while a search or its output runs.
// Each search step (advance, backtrack or the final give-up at node 0) runs
// ST_WAIT (row read from the row RAM) then ST_STEP (color pick); a found
// coloring adds an ST_WAIT to see the full level, so the search is data dependent.
// rsp_port then gives node_count words (node, color, found=1), the last one
// flagged, or a single not-found word (node 0, color 0, found 0, last 1).
// Output words leave one per cycle through an output register; a stalled
// rsp_port holds the word and pauses the output sequence.
// Reset clears node_count to 16, the colors and the state machine; stored
// rows are not cleared and must be written before use.
`default_nettype none

module graph_three_coloring_search #(
   parameter int MAX_NODES = gtc_pkg::DEF_MAX_NODES,
   parameter int NUM_COLORS = gtc_pkg::DEF_NUM_COLORS
) (
   input wire logic  clock,
   input wire logic  reset,
   gtc_req_if.sink   req_port,
   gtc_rsp_if.source rsp_port,
   gtc_csr_if.sink   csr_port
);

   gtc_pkg::ctrl_cmd_type cmd;
   gtc_pkg::dp_status_type sts;

   gtc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   gtc_dp #(
      .MAX_NODES  (MAX_NODES),
      .NUM_COLORS (NUM_COLORS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_port),
      .rsp   (rsp_port),
      .csr   (csr_port),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/gtc_ram.sv -----
`default_nettype none

module gtc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gtc_dp.sv -----
`default_nettype none
`include "assert_macros.svh"

module gtc_dp #(
   parameter int MAX_NODES = gtc_pkg::DEF_MAX_NODES,
   parameter int NUM_COLORS = gtc_pkg::DEF_NUM_COLORS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gtc_req_if.sink                    req,
   gtc_rsp_if.source                  rsp,
   gtc_csr_if.sink                    csr,
   input  wire gtc_pkg::ctrl_cmd_type cmd,
   output gtc_pkg::dp_status_type     sts
);

   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CMP_W = (CNT_W > gtc_pkg::ROW_INDEX_W) ? CNT_W : gtc_pkg::ROW_INDEX_W;
   localparam int NW = (CNT_W > gtc_pkg::COUNT_W) ? CNT_W : gtc_pkg::COUNT_W;
   localparam int LIM = (MAX_NODES < gtc_pkg::ROW_W) ? MAX_NODES : gtc_pkg::ROW_W;

   logic [gtc_pkg::COUNT_W-1:0] node_count_ff;
   logic [gtc_pkg::COLOR_W-1:0] colors_ff [MAX_NODES];
   logic [CNT_W-1:0]            level_ff;
   logic                        found_ff;

   logic                        rsp_valid_ff;
   logic [gtc_pkg::NODE_W-1:0]  rsp_node_ff;
   logic [gtc_pkg::COLOR_W-1:0] rsp_color_ff;
   logic                        rsp_found_ff;
   logic                        rsp_last_ff;

   logic [CNT_W-1:0]            n_eff;
   logic [CNT_W-1:0]            n_last;
   logic                        row_in_range;
   logic                        wr_en;
   logic [IDX_W-1:0]            lvl_idx;
   logic [gtc_pkg::ROW_W-1:0]   row;
   logic [gtc_pkg::COLOR_W-1:0] cur_color;
   logic [(2**gtc_pkg::COLOR_W)-1:0] blocked;
   logic                        fit;
   logic [gtc_pkg::COLOR_W-1:0] pick;
   logic                        at_last;

   // clamp the node count into 1..MAX_NODES
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (NW'(node_count_ff) > NW'(MAX_NODES)) begin
         n_eff = CNT_W'(MAX_NODES);
      end else begin
         n_eff = CNT_W'(node_count_ff);
      end
   end

   assign n_last = n_eff - CNT_W'(1);
   assign row_in_range = CMP_W'(req.row_index) < CMP_W'(MAX_NODES);
   assign req.ready = cmd.load_ready;
   assign wr_en = req.valid && req.ready && row_in_range;
   assign csr.ready = 1'b1;
   assign lvl_idx = IDX_W'(level_ff);

   gtc_ram #(
      .WIDTH (gtc_pkg::ROW_W),
      .DEPTH (MAX_NODES)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req.row_index)),
      .wr_data (req.row_bits),
      .rd_addr (lvl_idx),
      .rd_data (row)
   );

   assign cur_color = colors_ff[lvl_idx];

   // colors held by lower-numbered neighbours of the current node
   always_comb begin
      blocked = '0;
      for (int j = 0; j < LIM; j++) begin
         if ((CNT_W'(j) < level_ff) && row[j]) begin
            blocked[colors_ff[j]] = 1'b1;
         end
      end
   end

   // lowest free color above the one the node holds now
   always_comb begin
      fit = 1'b0;
      pick = gtc_pkg::COLOR_NONE;
      for (int c = NUM_COLORS; c >= 1; c--) begin
         if ((gtc_pkg::COLOR_W'(c) > cur_color) && !blocked[c]) begin
            fit = 1'b1;
            pick = gtc_pkg::COLOR_W'(c);
         end
      end
   end

   assign at_last = !found_ff || (level_ff == n_last);

   always_comb begin
      sts.trigger = req.valid && row_in_range && (CMP_W'(req.row_index) == CMP_W'(n_last));
      sts.fit = fit;
      sts.level_zero = (level_ff == '0);
      sts.level_full = (level_ff == n_eff);
      sts.out_free = !rsp_valid_ff || rsp.ready;
      sts.emit_last = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= gtc_pkg::NODE_COUNT_RESET;
         for (int i = 0; i < MAX_NODES; i++) begin
            colors_ff[i] <= gtc_pkg::COLOR_NONE;
         end
         level_ff <= '0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            node_count_ff <= csr.data;
         end
         if (cmd.start) begin
            for (int i = 0; i < MAX_NODES; i++) begin
               colors_ff[i] <= gtc_pkg::COLOR_NONE;
            end
            level_ff <= '0;
         end
         if (cmd.step_adv) begin
            colors_ff[lvl_idx] <= pick;
            level_ff <= level_ff + CNT_W'(1);
         end
         if (cmd.step_back) begin
            colors_ff[lvl_idx] <= gtc_pkg::COLOR_NONE;
            level_ff <= level_ff - CNT_W'(1);
         end
         if (cmd.emit_begin) begin
            level_ff <= '0;
            found_ff <= cmd.found;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            level_ff <= level_ff + CNT_W'(1);
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_node_ff <= gtc_pkg::NODE_W'(level_ff);
         rsp_color_ff <= found_ff ? cur_color : gtc_pkg::COLOR_NONE;
         rsp_found_ff <= found_ff;
         rsp_last_ff <= at_last;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.node = rsp_node_ff;
   assign rsp.color = rsp_color_ff;
   assign rsp.found = rsp_found_ff;
   assign rsp.last = rsp_last_ff;

   `ASSERT_NEVER(found_has_color, clock, reset,
      rsp_valid_ff && rsp_found_ff && (rsp_color_ff == gtc_pkg::COLOR_NONE),
      "found word without a color")
   `ASSERT_NEVER(miss_shape, clock, reset,
      rsp_valid_ff && !rsp_found_ff &&
      (!rsp_last_ff || (rsp_color_ff != gtc_pkg::COLOR_NONE) || (rsp_node_ff != '0)),
      "malformed not-found word")
   `ASSERT_PROP(last_node, clock, reset,
      (rsp_valid_ff && rsp_found_ff && rsp_last_ff) |->
      (rsp_node_ff == gtc_pkg::NODE_W'(n_last)),
      "last word not on the last node")

endmodule

`default_nettype wire

// ----- hw/rtl/gtc_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module gtc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gtc_pkg::dp_status_type sts,
   output gtc_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WAIT,
      ST_STEP,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            cmd.load_ready = 1'b1;
            if (sts.trigger) begin
               cmd.start = 1'b1;
               state_in = ST_WAIT;
            end
         end
         // row of the current level is being read
         ST_WAIT: begin
            if (sts.level_full) begin
               cmd.emit_begin = 1'b1;
               cmd.found = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (sts.fit) begin
               cmd.step_adv = 1'b1;
               state_in = ST_WAIT;
            end else if (sts.level_zero) begin
               cmd.emit_begin = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.step_back = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEVER(back_from_root, clock, reset, cmd.step_back && sts.level_zero, "backtrack below the first node")
   `ASSERT_PROP(emit_after_search, clock, reset, (state_ff == ST_EMIT) |-> $past(state_ff == ST_EMIT || state_ff == ST_WAIT || state_ff == ST_STEP), "emit entered from loading")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import gtc_pkg::*;

   typedef struct packed {
      logic [NODE_W-1:0]  node;
      logic [COLOR_W-1:0] color;
      logic               found;
      logic               last;
   } color_word_t;

   typedef struct packed {
      logic                   set_count;
      logic [COUNT_W-1:0]     count;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [ROW_W-1:0]       row_bits;
      logic                   typed;
      color_word_t            want;
   } row_case_t;

   localparam int MAX_N = DEF_MAX_NODES;
   localparam int STEP_BUDGET = 600;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ROWS = 84;
   localparam int IDLE_PCT [4] = '{0, 86, 0, 12};
   localparam int STALL_PCT [4] = '{0, 0, 86, 12};
   localparam logic [COLOR_W-1:0] COLOR_FIRST = 2'd1;

   localparam color_word_t NO_WORD = '0;
   localparam color_word_t NOT_FOUND =
      '{node: '0, color: COLOR_NONE, found: 1'b0, last: 1'b1};
   localparam color_word_t LONE_NODE =
      '{node: '0, color: COLOR_FIRST, found: 1'b1, last: 1'b1};

   // k4 on 0..3 with self loops, upper bits on 4..14, all bits on 15,
   // then one node (count 1 and count 0), count above the maximum,
   // and an odd wheel that needs full backtracking to give up
   localparam int OPENING_N = 25;
   localparam row_case_t OPENING_ROWS [OPENING_N] = '{
      '{1'b0, 5'd0,  4'd0,  16'hFFFF, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd1,  16'h0003, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd2,  16'h0007, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd3,  16'h000F, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd4,  16'hFFE0, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd5,  16'hFFC0, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd6,  16'hFF80, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd7,  16'hFF00, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd8,  16'hFE00, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd9,  16'hFC00, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd10, 16'hF800, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd11, 16'hF000, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd12, 16'hE000, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd13, 16'hC000, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd14, 16'h8000, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd15, 16'hFFFF, 1'b1, NOT_FOUND},
      '{1'b1, 5'd1,  4'd0,  16'hFFFF, 1'b1, LONE_NODE},
      '{1'b1, 5'd0,  4'd0,  16'h0001, 1'b1, LONE_NODE},
      '{1'b1, 5'd31, 4'd15, 16'h0000, 1'b1, NOT_FOUND},
      '{1'b1, 5'd6,  4'd0,  16'h003E, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd1,  16'h0025, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd2,  16'h000B, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd3,  16'h0015, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd4,  16'h0029, 1'b0, NO_WORD},
      '{1'b0, 5'd0,  4'd5,  16'h0013, 1'b1, NOT_FOUND}
   };

   logic clock;
   logic reset;

   gtc_req_if req_if ();
   gtc_rsp_if rsp_if ();
   gtc_csr_if csr_if ();

   graph_three_coloring_search u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   logic [MAX_N-1:0][ROW_W-1:0] row_store;
   logic [COUNT_W-1:0]          node_count;
   color_word_t                 pending_words [$];
   int                          mismatch_count;
   int                          rows_sent;
   int                          send_idle_pct;
   int                          stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int active_nodes(input logic [COUNT_W-1:0] cnt);
      if (cnt == '0) return 1;
      if (int'(cnt) > MAX_N) return MAX_N;
      return int'(cnt);
   endfunction

   // depth-first search, lowest fitting color first; gives up past max_steps
   function automatic bit find_coloring(input logic [MAX_N-1:0][ROW_W-1:0] rows,
                                        input int n, input int max_steps,
                                        output logic [MAX_N-1:0][COLOR_W-1:0] colors,
                                        output int steps);
      int lvl;
      int c;
      bit clash;
      colors = '0;
      lvl = 0;
      steps = 0;
      while (lvl < n) begin
         if (steps > max_steps) return 1'b0;
         steps++;
         c = int'(colors[lvl]) + 1;
         while (c <= DEF_NUM_COLORS) begin
            clash = 1'b0;
            for (int j = 0; j < lvl; j++)
               if (rows[lvl][j] && int'(colors[j]) == c) clash = 1'b1;
            if (!clash) break;
            c++;
         end
         if (c <= DEF_NUM_COLORS) begin
            colors[lvl] = COLOR_W'(c);
            lvl++;
         end else begin
            colors[lvl] = COLOR_NONE;
            if (lvl == 0) return 1'b0;
            lvl--;
         end
      end
      return 1'b1;
   endfunction

   task automatic accept_row(input logic [ROW_INDEX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                             input logic typed, input color_word_t want);
      logic [MAX_N-1:0][COLOR_W-1:0] colors;
      color_word_t w;
      int n;
      int steps;
      n = active_nodes(node_count);
      row_store[idx] = bits;
      if (int'(idx) == n - 1) begin
         if (typed) begin
            pending_words.push_back(want);
         end else if (find_coloring(row_store, n, 1 << 30, colors, steps)) begin
            for (int i = 0; i < n; i++) begin
               w.node = NODE_W'(i);
               w.color = colors[i];
               w.found = 1'b1;
               w.last = (i == n - 1);
               pending_words.push_back(w);
            end
         end else begin
            pending_words.push_back(NOT_FOUND);
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 200) $display("%0t: %s", $time, msg);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_row(input logic [ROW_INDEX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                           input logic typed, input color_word_t want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.row_index <= idx;
      req_if.row_bits <= bits;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      accept_row(idx, bits, typed, want);
      rows_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every expected word is out and the block is idle
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_node_count(input logic [COUNT_W-1:0] value);
      settle();
      csr_if.valid <= 1'b1;
      csr_if.data <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      node_count = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // a full graph in order; cheap searches only, later retries empty
   task automatic load_graph();
      logic [MAX_N-1:0][ROW_W-1:0]   graph;
      logic [MAX_N-1:0][ROW_W-1:0]   trial;
      logic [MAX_N-1:0][COLOR_W-1:0] colors;
      logic [COUNT_W-1:0]            cnt;
      int n;
      int pick;
      int density;
      int steps;
      int tries;
      bit found;
      if ($urandom_range(99) < 35) begin
         pick = $urandom_range(99);
         if (pick < 8) cnt = '0;
         else if (pick < 16) cnt = COUNT_W'(1);
         else if (pick < 28) cnt = COUNT_W'(MAX_N);
         else if (pick < 36) cnt = COUNT_W'($urandom_range(31, MAX_N + 1));
         else if (pick < 50) cnt = COUNT_W'($urandom_range(MAX_N, 9));
         else cnt = COUNT_W'($urandom_range(8, 2));
         write_node_count(cnt);
      end
      n = active_nodes(node_count);
      tries = 0;
      do begin
         case ($urandom_range(5))
            0: density = 0;
            1: density = 10;
            2: density = 25;
            3: density = 40;
            4: density = 60;
            default: density = 100;
         endcase
         if (tries >= 6) density = 0;
         graph = '0;
         for (int i = 0; i < n; i++)
            for (int j = 0; j < i; j++)
               if ($urandom_range(99) < density) begin
                  graph[i][j] = 1'b1;
                  graph[j][i] = 1'b1;
               end
         // diagonal and upper bits never count, so scramble them at times
         if ($urandom_range(2) == 0)
            for (int i = 0; i < n; i++)
               graph[i] = graph[i] ^ (ROW_W'($urandom()) &
                                      ~((ROW_W'(1) << i) - ROW_W'(1)));
         trial = row_store;
         for (int i = 0; i < n; i++) trial[i] = graph[i];
         found = find_coloring(trial, n, STEP_BUDGET, colors, steps);
         tries++;
      end while (steps > STEP_BUDGET);
      for (int i = 0; i < n; i++) send_row(ROW_INDEX_W'(i), graph[i], 1'b0, NO_WORD);
   endtask

   // rows out of order; one may land on the last node and start a search
   task automatic send_stray_rows();
      logic [MAX_N-1:0][ROW_W-1:0]   trial;
      logic [MAX_N-1:0][COLOR_W-1:0] colors;
      logic [ROW_INDEX_W-1:0]        idx;
      logic [ROW_W-1:0]              bits;
      int n;
      int steps;
      bit found;
      n = active_nodes(node_count);
      repeat ($urandom_range(4, 1)) begin
         idx = ROW_INDEX_W'($urandom_range(MAX_N - 1));
         bits = ROW_W'($urandom());
         if (int'(idx) == n - 1) begin
            trial = row_store;
            trial[idx] = bits;
            found = find_coloring(trial, n, STEP_BUDGET, colors, steps);
            if (steps > STEP_BUDGET) idx = idx + 1'b1;
         end
         send_row(idx, bits, 1'b0, NO_WORD);
      end
   endtask

   always @(negedge clock) rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      color_word_t got;
      color_word_t want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.node = rsp_if.node;
         got.color = rsp_if.color;
         got.found = rsp_if.found;
         got.last = rsp_if.last;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word: node %0d color %0d found %b last %b",
                                      got.node, got.color, got.found, got.last));
         end else begin
            want = pending_words.pop_front();
            if (got.node !== want.node || got.color !== want.color ||
                got.found !== want.found || got.last !== want.last)
               report_mismatch($sformatf(
                  "word node %0d color %0d found %b last %b, want %0d %0d %b %b",
                  got.node, got.color, got.found, got.last,
                  want.node, want.color, want.found, want.last));
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.row_index = '0;
      req_if.row_bits = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
      reset = 1'b1;
      node_count = NODE_COUNT_RESET;
      row_store = '0;
      mismatch_count = 0;
      rows_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int k = 0; k < OPENING_N; k++) begin
         if (OPENING_ROWS[k].set_count) write_node_count(OPENING_ROWS[k].count);
         send_row(OPENING_ROWS[k].row_index, OPENING_ROWS[k].row_bits,
                  OPENING_ROWS[k].typed, OPENING_ROWS[k].want);
      end

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = IDLE_PCT[ph];
         stall_pct = STALL_PCT[ph];
         while (rows_sent < OPENING_N + (ph + 1) * PHASE_ROWS) begin
            if ($urandom_range(99) < 80) load_graph();
            else send_stray_rows();
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- graph_three_coloring_search.f -----
+incdir+hw/rtl
hw/rtl/gtc_pkg.sv
hw/rtl/gtc_ifs.sv
hw/rtl/gtc_ram.sv
hw/rtl/gtc_dp.sv
hw/rtl/gtc_ctrl.sv
hw/rtl/graph_three_coloring_search.sv
tb/tb.sv
